/* rtl/les_pkg.sv */
package les_pkg;

    // Default sizing of the line buffer
    localparam int unsigned MAX_LINES_DEF = 8;
    localparam int unsigned LINE_CAP_DEF  = 128;

    // Fixed field widths of the stream payloads
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 8;
    localparam int unsigned SRC_W      = 3;
    localparam int unsigned OUT_DATA_W = 24;

    // Sort key selection
    typedef enum logic [1:0] {
        MODE_KEEP = 2'd0,
        MODE_LEX  = 2'd1,
        MODE_LEN  = 2'd2,
        MODE_RUN  = 2'd3
    } t_mode;

    // Result of comparing one byte of two lines
    typedef struct packed {
        logic differ;
        logic greater;
    } t_byte_cmp;

    function automatic logic is_letter(input logic [BYTE_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

/* rtl/les_store.sv */
module les_store #(
    parameter int unsigned AW = $clog2(les_pkg::MAX_LINES_DEF) + $clog2(les_pkg::LINE_CAP_DEF)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [les_pkg::BYTE_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr_a,
    input  logic [AW-1:0]               i_raddr_b,
    output les_pkg::t_byte_cmp          o_cmp
);

    localparam int unsigned DEPTH = 1 << AW;

    logic [les_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [les_pkg::BYTE_W-1:0] r_qa;
    logic [les_pkg::BYTE_W-1:0] r_qb;

    // Store one byte per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read the same offset of two lines, hold the pair until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_qa <= mem[i_raddr_a];
            r_qb <= mem[i_raddr_b];
        end
    end

    assign o_cmp.differ  = (r_qa != r_qb);
    assign o_cmp.greater = (r_qa > r_qb);

endmodule

/* rtl/line_exchange_sorter_top.sv */
// Channel     | Dir | Signals                    | Payload
// ------------+-----+----------------------------+-------------------------------------------
// byte in     | in  | i_s_tvalid / o_s_tready    | tdata[7:0] char_byte, tuser line_end,
//             |     |                            | tlast set_end
// order out   | out | o_m_tvalid / i_m_tready    | tdata[2:0] source_line, [10:3] line_length,
//             |     |                            | [18:11] letter_run, tuser truncated,
//             |     |                            | tlast last_of_set
// sort mode   | in  | i_cfg_we                   | i_cfg_wdata[1:0] sort_mode
//
// Cycles: one byte per cycle while a set loads. The byte with tlast closes the set and intake
// stops while the order memory is sorted and read out. Keep-order mode or a single line skips
// the sort; otherwise each outer pass reads entry i and its key, each compared pair reads entry j
// and its key and decides, lexicographic mode adds a read and compare per byte examined, and
// the pass writes entry i back. Readout reads the entry, then its key, then loads the output
// register; the order memory has one registered read port. Reset: synchronous; the line,
// length and order memories are not cleared, since only entries written for the current set
// are ever read. A stalled result holds in the output register and the readout waits for it.
module line_exchange_sorter_top #(
    parameter int unsigned MAX_LINES     = les_pkg::MAX_LINES_DEF,
    parameter int unsigned LINE_CAPACITY = les_pkg::LINE_CAP_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [les_pkg::BYTE_W-1:0]     i_s_tdata,   // [7:0] char_byte
    input  logic                           i_s_tuser,   // [0] line_end
    input  logic                           i_s_tlast,   // set_end
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [les_pkg::OUT_DATA_W-1:0] o_m_tdata,   // [2:0] source_line, [10:3] line_length,
                                                        // [18:11] letter_run, [23:19] zero
    output logic                           o_m_tuser,   // [0] truncated
    output logic                           o_m_tlast,   // last_of_set
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_wdata
);

    localparam int unsigned LW = $clog2(MAX_LINES);
    localparam int unsigned NW = $clog2(MAX_LINES + 1);
    localparam int unsigned XW = NW + 1;
    localparam int unsigned PW = $clog2(LINE_CAPACITY);
    localparam int unsigned CW = $clog2(LINE_CAPACITY + 1);
    localparam int unsigned AW = LW + PW;

    typedef struct packed {
        logic [CW-1:0] len;
        logic [CW-1:0] run;
        logic          trunc;
    } t_meta;

    typedef enum logic [12:0] {
        ST_LOAD     = 13'b0000000000001,
        ST_RD_I     = 13'b0000000000010,
        ST_GET_I    = 13'b0000000000100,
        ST_CUR_KEY  = 13'b0000000001000,
        ST_GET_J    = 13'b0000000010000,
        ST_KEY      = 13'b0000000100000,
        ST_LEX_RD   = 13'b0000001000000,
        ST_LEX_CMP  = 13'b0000010000000,
        ST_DECIDE   = 13'b0000100000000,
        ST_WB_I     = 13'b0001000000000,
        ST_OUT_RD   = 13'b0010000000000,
        ST_OUT_META = 13'b0100000000000,
        ST_OUT_PUT  = 13'b1000000000000
    } t_state;

    // Control registers
    t_state         r_state, n_state;
    les_pkg::t_mode r_mode, n_mode;
    logic [NW-1:0]  r_lines, n_lines;
    logic [CW-1:0]  r_pos, n_pos;
    logic [CW-1:0]  r_run, n_run;
    logic           r_trunc, n_trunc;
    logic           r_run_open, n_run_open;
    logic [NW-1:0]  r_n, n_n;
    logic           r_o_valid, n_o_valid;

    // Sort and readout working registers
    logic [LW-1:0]  r_i, n_i;
    logic [LW-1:0]  r_j, n_j;
    logic [LW-1:0]  r_cur, n_cur;
    logic [LW-1:0]  r_oth, n_oth;
    t_meta          r_cur_meta, n_cur_meta;
    t_meta          r_oth_meta, n_oth_meta;
    logic [CW-1:0]  r_k, n_k;
    logic           r_gt, n_gt;
    logic [LW-1:0]  r_o, n_o;
    logic [LW-1:0]  r_src, n_src;

    // Output register payload
    logic [les_pkg::SRC_W-1:0] r_o_src, n_o_src;
    logic [les_pkg::LEN_W-1:0] r_o_len, n_o_len;
    logic [les_pkg::LEN_W-1:0] r_o_run, n_o_run;
    logic                      r_o_trunc, n_o_trunc;
    logic                      r_o_last, n_o_last;

    // Order and per-line memories
    logic [LW-1:0] ord_mem [MAX_LINES];
    t_meta         meta_mem [MAX_LINES];
    logic [LW-1:0] ord_q;
    t_meta         meta_q;

    logic          ord_we, ord_re;
    logic [LW-1:0] ord_waddr, ord_wdata, ord_raddr;
    logic          meta_we, meta_re;
    logic [LW-1:0] meta_waddr, meta_raddr;
    t_meta         meta_wdata;

    logic          st_we, st_re;
    logic [AW-1:0] st_waddr, st_raddr_a, st_raddr_b;
    les_pkg::t_byte_cmp st_cmp;

    // Load path helpers
    logic          w_acc, w_room, w_fits, w_letter, w_close;
    logic [LW-1:0] w_line;
    logic [CW-1:0] w_pos_nx, w_run_nx, w_min_len;
    logic          w_trunc_nx, w_open_nx, w_gt;
    logic [NW-1:0] w_n_set;

    assign o_s_tready = (r_state == ST_LOAD);
    assign w_acc      = i_s_tvalid & o_s_tready;
    assign w_room     = (r_lines < NW'(MAX_LINES));
    assign w_line     = r_lines[LW-1:0];
    assign w_fits     = (r_pos < CW'(LINE_CAPACITY));
    assign w_letter   = les_pkg::is_letter(i_s_tdata);
    assign w_close    = i_s_tuser | i_s_tlast;
    assign w_pos_nx   = w_fits ? (r_pos + CW'(1)) : r_pos;
    assign w_run_nx   = (w_fits && r_run_open && w_letter) ? (r_run + CW'(1)) : r_run;
    assign w_open_nx  = w_fits ? (r_run_open & w_letter) : r_run_open;
    assign w_trunc_nx = r_trunc | ~w_fits;
    assign w_n_set    = w_room ? (r_lines + NW'(1)) : r_lines;
    assign w_min_len  = (r_cur_meta.len < r_oth_meta.len) ? r_cur_meta.len : r_oth_meta.len;

    // Pick the key comparison for the active mode
    always_comb begin
        unique case (r_mode)
            les_pkg::MODE_LEX: w_gt = r_gt;
            les_pkg::MODE_LEN: w_gt = (r_cur_meta.len > r_oth_meta.len);
            les_pkg::MODE_RUN: w_gt = (r_cur_meta.run > r_oth_meta.run);
            default:           w_gt = 1'b0;
        endcase
    end

    // Sequencer: load, exchange sort over the order memory, readout
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_lines    = r_lines;
        n_pos      = r_pos;
        n_run      = r_run;
        n_trunc    = r_trunc;
        n_run_open = r_run_open;
        n_n        = r_n;
        n_o_valid  = r_o_valid;
        n_i        = r_i;
        n_j        = r_j;
        n_cur      = r_cur;
        n_oth      = r_oth;
        n_cur_meta = r_cur_meta;
        n_oth_meta = r_oth_meta;
        n_k        = r_k;
        n_gt       = r_gt;
        n_o        = r_o;
        n_src      = r_src;
        n_o_src    = r_o_src;
        n_o_len    = r_o_len;
        n_o_run    = r_o_run;
        n_o_trunc  = r_o_trunc;
        n_o_last   = r_o_last;

        ord_we     = 1'b0;
        ord_waddr  = r_i;
        ord_wdata  = r_cur;
        ord_re     = 1'b0;
        ord_raddr  = r_i;
        meta_we    = 1'b0;
        meta_waddr = w_line;
        meta_wdata = '{len: w_pos_nx, run: w_run_nx, trunc: w_trunc_nx};
        meta_re    = 1'b0;
        meta_raddr = ord_q;
        st_we      = 1'b0;
        st_waddr   = {w_line, r_pos[PW-1:0]};
        st_re      = 1'b0;
        st_raddr_a = {r_cur, r_k[PW-1:0]};
        st_raddr_b = {r_oth, r_k[PW-1:0]};

        // Drop the output transaction once taken
        if (r_o_valid && i_m_tready) begin
            n_o_valid = 1'b0;
        end

        if (i_cfg_we) begin
            n_mode = les_pkg::t_mode'(i_cfg_wdata);
        end

        unique case (r_state)
            ST_LOAD: begin
                if (w_acc && w_room) begin
                    st_we      = w_fits;
                    n_pos      = w_pos_nx;
                    n_run      = w_run_nx;
                    n_trunc    = w_trunc_nx;
                    n_run_open = w_open_nx;
                    if (w_close) begin
                        meta_we    = 1'b1;
                        ord_we     = 1'b1;
                        ord_waddr  = w_line;
                        ord_wdata  = w_line;
                        n_lines    = r_lines + NW'(1);
                        n_pos      = '0;
                        n_run      = '0;
                        n_trunc    = 1'b0;
                        n_run_open = 1'b1;
                    end
                end
                // Close the set and start a fresh one
                if (w_acc && i_s_tlast) begin
                    n_n        = w_n_set;
                    n_lines    = '0;
                    n_pos      = '0;
                    n_run      = '0;
                    n_trunc    = 1'b0;
                    n_run_open = 1'b1;
                    n_i        = '0;
                    n_j        = LW'(1);
                    n_o        = '0;
                    if ((r_mode == les_pkg::MODE_KEEP) || (w_n_set < NW'(2))) begin
                        n_state = ST_OUT_RD;
                    end else begin
                        n_state = ST_RD_I;
                    end
                end
            end
            ST_RD_I: begin
                ord_re  = 1'b1;
                ord_raddr = r_i;
                n_state = ST_GET_I;
            end
            ST_GET_I: begin
                n_cur   = ord_q;
                meta_re = 1'b1;
                n_state = ST_CUR_KEY;
            end
            ST_CUR_KEY: begin
                n_cur_meta = meta_q;
                ord_re     = 1'b1;
                ord_raddr  = r_j;
                n_state    = ST_GET_J;
            end
            ST_GET_J: begin
                n_oth   = ord_q;
                meta_re = 1'b1;
                n_state = ST_KEY;
            end
            ST_KEY: begin
                n_oth_meta = meta_q;
                n_k        = '0;
                n_state    = (r_mode == les_pkg::MODE_LEX) ? ST_LEX_RD : ST_DECIDE;
            end
            ST_LEX_RD: begin
                // Equal common prefix: the longer line is greater
                if (r_k == w_min_len) begin
                    n_gt    = (r_cur_meta.len > r_oth_meta.len);
                    n_state = ST_DECIDE;
                end else begin
                    st_re   = 1'b1;
                    n_state = ST_LEX_CMP;
                end
            end
            ST_LEX_CMP: begin
                if (st_cmp.differ) begin
                    n_gt    = st_cmp.greater;
                    n_state = ST_DECIDE;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = ST_LEX_RD;
                end
            end
            ST_DECIDE: begin
                // Swap only on a strictly greater earlier key
                if (w_gt) begin
                    ord_we     = 1'b1;
                    ord_waddr  = r_j;
                    ord_wdata  = r_cur;
                    n_cur      = r_oth;
                    n_cur_meta = r_oth_meta;
                end
                if ((XW'(r_j) + XW'(1)) < XW'(r_n)) begin
                    ord_re    = 1'b1;
                    ord_raddr = r_j + LW'(1);
                    n_j       = r_j + LW'(1);
                    n_state   = ST_GET_J;
                end else begin
                    n_state = ST_WB_I;
                end
            end
            ST_WB_I: begin
                ord_we    = 1'b1;
                ord_waddr = r_i;
                ord_wdata = r_cur;
                if ((XW'(r_i) + XW'(2)) < XW'(r_n)) begin
                    ord_re    = 1'b1;
                    ord_raddr = r_i + LW'(1);
                    n_i       = r_i + LW'(1);
                    n_j       = r_i + LW'(2);
                    n_state   = ST_GET_I;
                end else begin
                    n_o     = '0;
                    n_state = ST_OUT_RD;
                end
            end
            ST_OUT_RD: begin
                ord_re    = 1'b1;
                ord_raddr = r_o;
                n_state   = ST_OUT_META;
            end
            ST_OUT_META: begin
                n_src   = ord_q;
                meta_re = 1'b1;
                n_state = ST_OUT_PUT;
            end
            ST_OUT_PUT: begin
                // Load the output register when it is free or being emptied
                if (!r_o_valid || i_m_tready) begin
                    n_o_valid = 1'b1;
                    n_o_src   = les_pkg::SRC_W'(r_src);
                    n_o_len   = les_pkg::LEN_W'(meta_q.len);
                    n_o_run   = les_pkg::LEN_W'(meta_q.run);
                    n_o_trunc = meta_q.trunc;
                    n_o_last  = ((XW'(r_o) + XW'(1)) == XW'(r_n));
                    if ((XW'(r_o) + XW'(1)) == XW'(r_n)) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_o     = r_o + LW'(1);
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_mode     <= les_pkg::MODE_KEEP;
            r_lines    <= '0;
            r_pos      <= '0;
            r_run      <= '0;
            r_trunc    <= 1'b0;
            r_run_open <= 1'b1;
            r_n        <= '0;
            r_o_valid  <= 1'b0;
            r_i        <= '0;
            r_j        <= '0;
            r_o        <= '0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_lines    <= n_lines;
            r_pos      <= n_pos;
            r_run      <= n_run;
            r_trunc    <= n_trunc;
            r_run_open <= n_run_open;
            r_n        <= n_n;
            r_o_valid  <= n_o_valid;
            r_i        <= n_i;
            r_j        <= n_j;
            r_o        <= n_o;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_oth      <= n_oth;
        r_cur_meta <= n_cur_meta;
        r_oth_meta <= n_oth_meta;
        r_k        <= n_k;
        r_gt       <= n_gt;
        r_src      <= n_src;
        r_o_src    <= n_o_src;
        r_o_len    <= n_o_len;
        r_o_run    <= n_o_run;
        r_o_trunc  <= n_o_trunc;
        r_o_last   <= n_o_last;
    end

    // Order memory: loading, sorting and readout never touch one entry in the same cycle
    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        if (ord_re) begin
            ord_q <= ord_mem[ord_raddr];
        end
    end

    // Per-line length, letter run and truncation mark, written as each line closes
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (meta_re) begin
            meta_q <= meta_mem[meta_raddr];
        end
    end

    les_store #(
        .AW (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (st_we),
        .i_waddr   (st_waddr),
        .i_wdata   (i_s_tdata),
        .i_re      (st_re),
        .i_raddr_a (st_raddr_a),
        .i_raddr_b (st_raddr_b),
        .o_cmp     (st_cmp)
    );

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {{(les_pkg::OUT_DATA_W - les_pkg::SRC_W - 2 * les_pkg::LEN_W){1'b0}},
                         r_o_run, r_o_len, r_o_src};
    assign o_m_tuser  = r_o_trunc;
    assign o_m_tlast  = r_o_last;

    // Readout index stays inside the loaded set
    a_out_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_OUT_RD) || (r_state == ST_OUT_META) || (r_state == ST_OUT_PUT))
        |-> (XW'(r_o) < XW'(r_n)))
        else $error("readout index beyond loaded lines");

    // Compared pair is ordered and inside the set
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE) |-> ((r_i < r_j) && (XW'(r_j) < XW'(r_n))))
        else $error("exchange pair out of order or range");

    // Write position never passes the line capacity
    a_pos_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= CW'(LINE_CAPACITY)))
        else $error("write position beyond capacity");

    // A result appears only from the readout step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == ST_OUT_PUT))
        else $error("result raised outside readout");

endmodule
